[design/totb_pkg.sv]
// Shared constants and types for the thruster on-time timer bank.
`timescale 1ns / 1ps

package totb_pkg;

  localparam int MaxThrusters = 16;
  localparam int ResultCap    = 16;
  localparam int ActiveLimit  = (MaxThrusters < ResultCap) ? MaxThrusters : ResultCap;
  localparam int IdxW         = (MaxThrusters > 1) ? $clog2(MaxThrusters) : 1;

  localparam int OpW     = 2;
  localparam int TidW    = 4;
  localparam int OnTimeW = 40;
  localparam int MagW    = 32;
  localparam int TimeW   = 64;
  localparam int RemW    = 39;
  localparam int DtW     = RemW + 1;
  localparam int NumW    = 5;

  localparam int InDataW  = 144;
  localparam int OutDataW = 40;

  localparam logic [OpW-1:0] OpLoad   = 2'd0;
  localparam logic [OpW-1:0] OpUpdate = 2'd1;
  localparam logic [OpW-1:0] OpSetMag = 2'd2;

  typedef logic [RemW-1:0] rem_t;
  typedef logic [MagW-1:0] mag_t;

endpackage

[design/totb_sat_sub.sv]
// Shared saturating subtract-and-compare unit for the timer countdown.
`timescale 1ns / 1ps

module totb_sat_sub (
  input  totb_pkg::rem_t            rem_i,
  input  logic [totb_pkg::DtW-1:0]  dt_i,
  output totb_pkg::rem_t            res_o
);
  import totb_pkg::*;

  logic [DtW-1:0] rem_ext;

  assign rem_ext = {1'b0, rem_i};
  assign res_o   = (rem_ext > dt_i) ? (rem_i - dt_i[RemW-1:0]) : '0;

endmodule

[design/thruster_on_time_timer_bank.sv]
// Top level of the thruster on-time timer bank.
`timescale 1ns / 1ps

// A load (opcode 0) or magnitude write (opcode 2) is written straight into its
// timer slot. A time update (opcode 1) first registers the elapsed time and
// then sweeps one timer slot per cycle, all MaxThrusters slots in order, as a
// single saturating subtract-compare unit visits the timers; the sweep stalls
// in any cycle in which a result cannot move into a full output register.
// Results for slots 0 to n-1 leave in index order, tlast on the last; n is
// num_thrusters clamped to 1..16. The input is not ready while an update sweeps.
module thruster_on_time_timer_bank (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [totb_pkg::NumW-1:0]        cfg_wdata_i,   // num_thrusters
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // thruster_index, on_time_ns, magnitude, now_ns, zero pad
  input  logic [totb_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic [totb_pkg::OpW-1:0]         s_axis_tuser,  // opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_thruster, force_res, zero pad
  output logic [totb_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import totb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  state_e                state_q;
  logic [IdxW-1:0]       idx_q;
  logic [DtW-1:0]        dt_q;
  logic [TimeW-1:0]      last_q;
  logic                  pending_q;
  logic [NumW-1:0]       num_q;
  rem_t                  rem_q [MaxThrusters];
  mag_t                  mag_q [MaxThrusters];
  logic                  out_valid_q;
  logic [TidW-1:0]       out_tid_q;
  mag_t                  out_force_q;
  logic                  out_last_q;

  logic [TidW-1:0]       in_tid;
  logic [OnTimeW-1:0]    in_on_time;
  mag_t                  in_mag;
  logic [TimeW-1:0]      in_now;
  logic                  in_xfer;
  logic                  in_tid_ok;
  logic [IdxW-1:0]       in_slot;
  logic [TimeW-1:0]      diff;
  logic [DtW-1:0]        dt_d;
  logic [NumW-1:0]       n_act;
  logic                  emit;
  logic                  advance;
  logic                  out_load;
  rem_t                  sub_res;

  assign in_tid     = s_axis_tdata[3:0];
  assign in_on_time = s_axis_tdata[43:4];
  assign in_mag     = s_axis_tdata[75:44];
  assign in_now     = s_axis_tdata[139:76];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_tid_ok     = int'(in_tid) < MaxThrusters;
  assign in_slot       = IdxW'(in_tid);

  assign diff = (in_now > last_q) ? (in_now - last_q) : '0;
  always_comb begin
    if (pending_q) begin
      dt_d = '0;
    end else begin
      dt_d = {(|diff[TimeW-1:RemW]), diff[RemW-1:0]};
    end
  end

  always_comb begin
    if (num_q == '0) begin
      n_act = NumW'(1);
    end else if (int'(num_q) > ActiveLimit) begin
      n_act = NumW'(ActiveLimit);
    end else begin
      n_act = num_q;
    end
  end

  assign emit     = int'(idx_q) < int'(n_act);
  assign advance  = !emit || !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_SWEEP) && advance && emit;

  totb_sat_sub u_sat_sub (
    .rem_i (rem_q[idx_q]),
    .dt_i  (dt_q),
    .res_o (sub_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NumW'(1);
    end else if (cfg_we_i) begin
      num_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      dt_q        <= '0;
      last_q      <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_tid_q   <= '0;
      out_force_q <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < MaxThrusters; i++) begin
        rem_q[i] <= '0;
        mag_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser)
              OpLoad: begin
                if (in_tid_ok) begin
                  rem_q[in_slot] <= in_on_time[OnTimeW-1] ? '0 : in_on_time[RemW-1:0];
                  pending_q      <= 1'b1;
                end
              end
              OpSetMag: begin
                if (in_tid_ok) begin
                  mag_q[in_slot] <= in_mag;
                end
              end
              OpUpdate: begin
                dt_q      <= dt_d;
                last_q    <= in_now;
                pending_q <= 1'b0;
                idx_q     <= '0;
                state_q   <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          if (advance) begin
            rem_q[idx_q] <= sub_res;
            if (emit) begin
              out_tid_q   <= TidW'(idx_q);
              out_force_q <= (sub_res != '0) ? mag_q[idx_q] : '0;
              out_last_q  <= (int'(idx_q) + 1) == int'(n_act);
            end
            if (int'(idx_q) == MaxThrusters - 1) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_force_q, out_tid_q};
  assign m_axis_tlast  = out_last_q;

  a_out_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_SWEEP))
    else $error("result appeared outside an update sweep");

  a_update_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser == OpUpdate) |=> (state_q == ST_SWEEP && idx_q == '0
      && !pending_q))
    else $error("update did not start a sweep at slot zero");

  a_no_increase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && advance) |=> (rem_q[$past(idx_q)] <= $past(rem_q[idx_q])))
    else $error("timer grew during countdown");

endmodule

[tb/sv/thruster_on_time_timer_bank_tb.sv]
// Self-checking testbench for the thruster on-time timer bank.
`timescale 1ns / 1ps

module thruster_on_time_timer_bank_tb;
  import totb_pkg::*;

  localparam logic [OpW-1:0] OpNone = 2'd3;

  typedef struct {
    logic [TidW-1:0] thr;
    logic [MagW-1:0] force_val;
    logic            last;
  } force_exp_t;

  class force_scoreboard;
    rem_t              remaining[MaxThrusters];
    mag_t              thrust[MaxThrusters];
    logic [TimeW-1:0]  last_ns;
    bit                pending;
    logic [NumW-1:0]   num_raw;
    force_exp_t        expected_q[$];
    int                errors;
    int                results_seen;

    function new();
      for (int i = 0; i < MaxThrusters; i++) begin
        remaining[i] = '0;
        thrust[i]    = '0;
      end
      last_ns      = '0;
      pending      = 0;
      num_raw      = 5'd1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_count(logic [NumW-1:0] v);
      num_raw = v;
    endfunction

    function void note_input(logic [OpW-1:0] op, logic [TidW-1:0] idx,
                             logic [OnTimeW-1:0] ont, logic [MagW-1:0] mag,
                             logic [TimeW-1:0] now);
      logic [TimeW-1:0] dt;
      int               n;
      force_exp_t       e;
      case (op)
        OpLoad: begin
          if (idx < MaxThrusters) begin
            remaining[idx] = ont[OnTimeW-1] ? '0 : ont[RemW-1:0];
            pending = 1;
          end
        end
        OpSetMag: begin
          if (idx < MaxThrusters) thrust[idx] = mag;
        end
        OpUpdate: begin
          if (pending) begin
            pending = 0;
          end else begin
            dt = (now > last_ns) ? now - last_ns : '0;
            for (int i = 0; i < MaxThrusters; i++) begin
              remaining[i] = ({25'd0, remaining[i]} > dt) ? remaining[i] - dt[RemW-1:0] : '0;
            end
          end
          last_ns = now;
          n = num_raw;
          if (n < 1) n = 1;
          if (n > ActiveLimit) n = ActiveLimit;
          for (int i = 0; i < n; i++) begin
            e.thr       = i[TidW-1:0];
            e.force_val = (remaining[i] != '0) ? thrust[i] : '0;
            e.last      = (i + 1 == n);
            expected_q.insert(expected_q.size(), e);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [TidW-1:0] thr, logic [MagW-1:0] fv, logic last);
      force_exp_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_thruster %0d force_res %0d last %0b", thr, fv, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (thr !== e.thr) begin
        $error("out_thruster expected %0d got %0d", e.thr, thr);
        errors++;
      end
      if (fv !== e.force_val) begin
        $error("force_res expected %0d got %0d", e.force_val, fv);
        errors++;
      end
      if (last !== e.last) begin
        $error("last expected %0b got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [NumW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  force_scoreboard sb = new();
  bit               calm;
  bit               hold_done;
  logic [TimeW-1:0] cur_ns;

  thruster_on_time_timer_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[TidW-1:0], m_axis_tdata[TidW+MagW-1:TidW], m_axis_tlast);
  end

  // result sink with random stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.results_seen >= 40) begin
        hold_done = 1;
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      m_axis_tready = calm || ($urandom_range(99) >= 9);
    end
  end

  task automatic send_item(logic [OpW-1:0] op, logic [TidW-1:0] idx,
                           logic [OnTimeW-1:0] ont, logic [MagW-1:0] mag,
                           logic [TimeW-1:0] now);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'd0, now, mag, ont, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, idx, ont, mag, now);
  endtask

  task automatic write_count(logic [NumW-1:0] v);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_count(v);
  endtask

  task automatic send_random();
    int               r;
    logic [OpW-1:0]   op;
    logic [OnTimeW-1:0] ont;
    logic [TimeW-1:0] now;
    r   = $urandom_range(99);
    op  = (r < 30) ? OpLoad : (r < 55) ? OpSetMag : (r < 94) ? OpUpdate : OpNone;
    r   = $urandom_range(99);
    if (r < 8)       ont = OnTimeW'({$urandom, $urandom});
    else if (r < 16) ont = -OnTimeW'($urandom_range(5000, 1));
    else             ont = OnTimeW'($urandom_range(6000));
    r = $urandom_range(99);
    if (r < 3)       cur_ns = {$urandom, $urandom};
    else if (r < 8)  cur_ns = cur_ns - TimeW'($urandom_range(1500));
    else             cur_ns = cur_ns + TimeW'($urandom_range(3000));
    now = (op == OpUpdate) ? cur_ns : {$urandom, $urandom};
    send_item(op, TidW'($urandom_range(15)), ont, $urandom, now);
  endtask

  initial begin
    logic [NumW-1:0] settings[9] = '{5'd16, 5'd31, 5'd4, 5'd0, 5'd16, 5'd1, 5'd17, 5'd9, 5'd16};
    int              sent;
    int              waited;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpNone;
    calm          = 0;
    hold_done     = 0;
    cur_ns        = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset count, extremes, pending loads, backwards and huge time steps
    send_item(OpUpdate, 4'd0, '0, '0, 64'd0);
    send_item(OpSetMag, 4'd0, '0, 32'hFFFF_FFFF, '0);
    send_item(OpSetMag, 4'd15, '1, 32'hA5A5_5A5A, '1);
    send_item(OpLoad, 4'd0, 40'h7F_FFFF_FFFF, '0, '0);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd100);
    write_count(5'd16);
    send_item(OpLoad, 4'd15, 40'h80_0000_0000, '0, '0);
    send_item(OpLoad, 4'd3, 40'hFF_FFFF_FFFF, '0, '0);
    send_item(OpLoad, 4'd1, 40'd500, '0, '0);
    send_item(OpSetMag, 4'd1, '0, 32'd1234, '0);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd200);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd50);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd549);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd551);
    send_item(OpNone, 4'd7, '1, '1, '1);
    send_item(OpUpdate, 4'd0, '0, '0, '1);
    send_item(OpLoad, 4'd2, 40'd10, '0, '0);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd0);
    send_item(OpUpdate, 4'd0, '0, '0, 64'd3);
    cur_ns = 64'd3;

    foreach (settings[p]) begin
      write_count(settings[p]);
      calm = (p == 4);
      sent = 0;
      while (sent < 23) begin
        send_random();
        if (s_axis_tuser != OpNone) sent++;
      end
    end
    calm = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (40) @(negedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
